[hw/rtl/ntsc_pkg.sv]
// shared types and constants for the nixie tube scan controller
// no dependencies

package ntsc_pkg;

  localparam int TUBE_COUNT    = 6;
  localparam int POS_W         = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
  localparam int WRITTEN_TUBES = 6;
  localparam int DIGIT_W       = 4;
  localparam int DIGIT_COUNT   = 10;
  localparam int ANODE_W       = 6;
  localparam int CATHODE_W     = 10;
  localparam int SEC_W         = 32;

  localparam int INTERVAL_W    = 17;
  localparam int FRAME_W       = 10;
  localparam int CYCLES_W      = 4;
  localparam int CFG_DATA_W    = 17;
  localparam int CFG_IDX_W     = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(3600);
  localparam logic [FRAME_W-1:0]    FRAME_RST    = FRAME_W'(30);
  localparam logic [CYCLES_W-1:0]   CYCLES_RST   = CYCLES_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES   = 2'd2;

  localparam logic [1:0] ACT_SCAN   = 2'd0;
  localparam logic [1:0] ACT_SECOND = 2'd1;
  localparam logic [1:0] ACT_MS     = 2'd2;
  localparam logic [1:0] ACT_WRITE  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } in_req_t;

  typedef struct packed {
    logic [ANODE_W-1:0]   anode_lines;
    logic [CATHODE_W-1:0] cathode_lines;
    logic                 colon_line;
    logic                 run_active;
  } out_rsp_t;

endpackage

[hw/rtl/nixie_tube_scan_controller_top.sv]
// nixie tube scan controller: multiplexed scan, colon and anti-poisoning runs
// depends on ntsc_pkg
//
//   channel | direction | handshake           | payload
//   in_     | request   | in_valid / in_ready | ntsc_pkg::in_req_t
//   out_    | result    | out_valid/out_ready | ntsc_pkg::out_rsp_t
//   cfg_    | write     | cfg_we              | cfg_index, cfg_wdata
//
// one request per cycle sustained while out_ready accepts results; a request
// waits in the input register; its result enters the output register as it leaves
// all state updates in a single pass when a request leaves the input register
// a stalled output holds its result; an empty input register takes one more request
// reset is synchronous and active low, and needs no clearing pass

module nixie_tube_scan_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ntsc_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ntsc_pkg::out_rsp_t              out_data,
  input  logic                            cfg_we,
  input  logic [ntsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TC = ntsc_pkg::TUBE_COUNT;
  localparam int PW = ntsc_pkg::POS_W;
  localparam int DW = ntsc_pkg::DIGIT_W;

  // configuration
  logic [ntsc_pkg::INTERVAL_W-1:0] interval_r;
  logic [ntsc_pkg::FRAME_W-1:0]    frame_len_r;
  logic [ntsc_pkg::CYCLES_W-1:0]   cycles_r;

  // pipeline
  logic               req_valid_r;
  ntsc_pkg::in_req_t  req_r;
  logic               out_valid_r;
  ntsc_pkg::out_rsp_t out_data_r, out_data_nxt;
  logic               advance, fire;

  // display state
  logic [DW-1:0]                   digit_r [TC];
  logic [DW-1:0]                   digit_nxt [TC];
  logic [PW-1:0]                   scan_pos_r, scan_pos_nxt;
  logic                            blank_next_r, blank_next_nxt;
  logic [ntsc_pkg::ANODE_W-1:0]    anode_r, anode_nxt;
  logic [ntsc_pkg::CATHODE_W-1:0]  cathode_r, cathode_nxt;
  logic                            colon_r, colon_nxt;
  logic [ntsc_pkg::SEC_W-1:0]      seconds_r, seconds_nxt;
  logic [ntsc_pkg::SEC_W-1:0]      elapsed_r, elapsed_nxt;
  logic                            run_r, run_nxt;
  logic [ntsc_pkg::FRAME_W-1:0]    frame_cnt_r, frame_cnt_nxt;
  logic [DW-1:0]                   sweep_digit_r, sweep_digit_nxt;
  logic [ntsc_pkg::CYCLES_W-1:0]   sweep_cnt_r, sweep_cnt_nxt;

  // helpers
  logic [PW-1:0]                   pos_sel;
  logic [PW:0]                     pos_inc;
  logic [DW-1:0]                   cur_digit;
  logic [ntsc_pkg::FRAME_W-1:0]    flen, frame_inc;
  logic [DW:0]                     sweep_inc;
  logic [ntsc_pkg::CYCLES_W-1:0]   cnt_inc;
  logic                            fill_en;
  logic [DW-1:0]                   fill_val;

  function automatic logic [DW-1:0] wr_digit(input ntsc_pkg::in_req_t r, input int idx);
    logic [DW-1:0] v;
    case (idx)
      0:       v = DW'(r.hour_tens);
      1:       v = r.hour_ones;
      2:       v = DW'(r.minute_tens);
      3:       v = r.minute_ones;
      4:       v = DW'(r.second_tens);
      5:       v = r.second_ones;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign advance   = !out_valid_r || out_ready;
  assign fire      = req_valid_r && advance;
  assign in_ready  = !req_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_sel   = (32'(scan_pos_r) >= 32'(TC)) ? '0 : scan_pos_r;
  assign pos_inc   = {1'b0, pos_sel} + 1'b1;
  assign cur_digit = digit_r[pos_sel];
  assign flen      = (frame_len_r == '0) ? ntsc_pkg::FRAME_W'(1) : frame_len_r;
  assign frame_inc = frame_cnt_r + 1'b1;
  assign sweep_inc = {1'b0, sweep_digit_r} + 1'b1;
  assign cnt_inc   = sweep_cnt_r + 1'b1;

  always_comb begin
    scan_pos_nxt    = scan_pos_r;
    blank_next_nxt  = blank_next_r;
    anode_nxt       = anode_r;
    cathode_nxt     = cathode_r;
    colon_nxt       = colon_r;
    seconds_nxt     = seconds_r;
    elapsed_nxt     = elapsed_r;
    run_nxt         = run_r;
    frame_cnt_nxt   = frame_cnt_r;
    sweep_digit_nxt = sweep_digit_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    fill_en         = 1'b0;
    fill_val        = '0;
    for (int i = 0; i < TC; i++) begin
      digit_nxt[i] = digit_r[i];
    end

    case (req_r.action)
      ntsc_pkg::ACT_SCAN: begin
        anode_nxt   = '0;
        cathode_nxt = '0;
        if (!blank_next_r) begin
          anode_nxt    = ntsc_pkg::ANODE_W'(1) << pos_sel;
          cathode_nxt  = (cur_digit <= DW'(9)) ? (ntsc_pkg::CATHODE_W'(1) << cur_digit) : '0;
          scan_pos_nxt = (32'(pos_inc) >= 32'(TC)) ? '0 : pos_inc[PW-1:0];
        end
        blank_next_nxt = !blank_next_r;
      end
      ntsc_pkg::ACT_SECOND: begin
        seconds_nxt = seconds_r + 1'b1;
        elapsed_nxt = elapsed_r + 1'b1;
        colon_nxt   = !colon_r;
        if (!run_r && (seconds_nxt != '0) &&
            (elapsed_nxt >= ntsc_pkg::SEC_W'(interval_r))) begin
          elapsed_nxt = '0;
          if (cycles_r != '0) begin
            run_nxt         = 1'b1;
            frame_cnt_nxt   = '0;
            sweep_digit_nxt = '0;
            sweep_cnt_nxt   = '0;
            fill_en         = 1'b1;
            fill_val        = '0;
          end
        end
      end
      ntsc_pkg::ACT_MS: begin
        if (run_r) begin
          frame_cnt_nxt = frame_inc;
          if (frame_inc >= flen) begin
            frame_cnt_nxt = '0;
            if (sweep_inc >= (DW+1)'(ntsc_pkg::DIGIT_COUNT)) begin
              sweep_digit_nxt = '0;
              sweep_cnt_nxt   = cnt_inc;
              if (cnt_inc >= cycles_r) begin
                run_nxt       = 1'b0;
                sweep_cnt_nxt = '0;
              end else begin
                fill_en  = 1'b1;
                fill_val = '0;
              end
            end else begin
              sweep_digit_nxt = sweep_inc[DW-1:0];
              fill_en         = 1'b1;
              fill_val        = sweep_inc[DW-1:0];
            end
          end
        end
      end
      ntsc_pkg::ACT_WRITE: begin
        if (!run_r) begin
          for (int i = 0; i < TC; i++) begin
            if (i < ntsc_pkg::WRITTEN_TUBES) begin
              digit_nxt[i] = wr_digit(req_r, i);
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (fill_en) begin
      for (int i = 0; i < TC; i++) begin
        digit_nxt[i] = fill_val;
      end
    end

    out_data_nxt.anode_lines   = anode_nxt;
    out_data_nxt.cathode_lines = cathode_nxt;
    out_data_nxt.colon_line    = colon_nxt;
    out_data_nxt.run_active    = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= ntsc_pkg::INTERVAL_RST;
      frame_len_r <= ntsc_pkg::FRAME_RST;
      cycles_r    <= ntsc_pkg::CYCLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ntsc_pkg::CFG_INTERVAL: interval_r  <= cfg_wdata[ntsc_pkg::INTERVAL_W-1:0];
        ntsc_pkg::CFG_FRAME:    frame_len_r <= cfg_wdata[ntsc_pkg::FRAME_W-1:0];
        ntsc_pkg::CFG_CYCLES:   cycles_r    <= cfg_wdata[ntsc_pkg::CYCLES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= req_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TC; i++) begin
        digit_r[i] <= '0;
      end
      scan_pos_r    <= '0;
      blank_next_r  <= 1'b1;
      anode_r       <= '0;
      cathode_r     <= '0;
      colon_r       <= 1'b0;
      seconds_r     <= '0;
      elapsed_r     <= '0;
      run_r         <= 1'b0;
      frame_cnt_r   <= '0;
      sweep_digit_r <= '0;
      sweep_cnt_r   <= '0;
    end else if (fire) begin
      for (int i = 0; i < TC; i++) begin
        digit_r[i] <= digit_nxt[i];
      end
      scan_pos_r    <= scan_pos_nxt;
      blank_next_r  <= blank_next_nxt;
      anode_r       <= anode_nxt;
      cathode_r     <= cathode_nxt;
      colon_r       <= colon_nxt;
      seconds_r     <= seconds_nxt;
      elapsed_r     <= elapsed_nxt;
      run_r         <= run_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      sweep_digit_r <= sweep_digit_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
    end
  end

endmodule
